### rtl/rv32ex_pkg.sv
// Shared types, opcode constants and decode helpers for the RV32I subset execute unit.
// No dependencies; imported by the execute stage and the top level.
`default_nettype none

package rv32ex_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    // funct7 values for register-register operations
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 values
    localparam logic [2:0] F3_ADDSUB = 3'b000;
    localparam logic [2:0] F3_SLL    = 3'b001;
    localparam logic [2:0] F3_XOR    = 3'b100;
    localparam logic [2:0] F3_SRL    = 3'b101;
    localparam logic [2:0] F3_OR     = 3'b110;
    localparam logic [2:0] F3_AND    = 3'b111;
    localparam logic [2:0] F3_LB     = 3'b000;
    localparam logic [2:0] F3_LW     = 3'b010;
    localparam logic [2:0] F3_SW     = 3'b010;
    localparam logic [2:0] F3_BEQ    = 3'b000;
    localparam logic [2:0] F3_BNE    = 3'b001;
    localparam logic [2:0] F3_BLT    = 3'b100;
    localparam logic [2:0] F3_BGE    = 3'b101;

    // Result of one instruction as it travels down the pipe
    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] wval;
        logic        is_load;
        logic        is_lb;
        logic [1:0]  boff;
        logic        st;
        logic [31:0] sval;
        logic        taken;
        logic        bad;
    } pipe_t;

    // Execute stage output: pipe payload plus the data byte address
    typedef struct packed {
        pipe_t       res;
        logic [31:0] addr;
    } exec_t;

    // Register file contents after reset
    function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd1:    v = 32'd11;
            5'd3:    v = 32'd3;
            5'd5:    v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Does the word read rs1 as an operand
    function automatic logic uses_rs1(input logic [31:0] w);
        return (w[6:0] == OPC_OP) || (w[6:0] == OPC_LOAD) ||
               (w[6:0] == OPC_STORE) || (w[6:0] == OPC_BRANCH);
    endfunction

    // Does the word read rs2 as an operand
    function automatic logic uses_rs2(input logic [31:0] w);
        return (w[6:0] == OPC_OP) || (w[6:0] == OPC_STORE) || (w[6:0] == OPC_BRANCH);
    endfunction

endpackage

`default_nettype wire

### rtl/rv32i_subset_execute_unit_top.sv
// RV32I subset execute unit: register file and data store in synchronous RAMs; uses all rtl files.
// Pipeline: an accepted instruction word passes through the E, R1, R2, M and output registers.
// Throughput: one word per cycle while the result side does not stall; a word reading a register
// loaded by a word still in R1 or R2 waits in E until the load data arrives from the data store.
// Reset: a clearing pass over max(DATA_WORDS, 32) entries loads register and store reset values.
`default_nettype none

module rv32i_subset_execute_unit_top #(
    parameter int DATA_WORDS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start_address_we,
    input  logic [31:0]        start_address,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instr_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        next_fetch_address,
    output logic               reg_write_valid,
    output logic [4:0]         reg_write_index,
    output logic signed [31:0] reg_write_value,
    output logic               store_valid,
    output logic [4:0]         store_word_index,
    output logic signed [31:0] store_value,
    output logic               branch_taken,
    output logic               unsupported
);

    import rv32ex_pkg::*;

    localparam int DAW       = $clog2(DATA_WORDS);
    localparam int CLR_DEPTH = (DATA_WORDS > 32) ? DATA_WORDS : 32;
    localparam int CW        = $clog2(CLR_DEPTH);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_DEPTH - 1);
    localparam logic [CW:0]   RF_LIM   = (CW+1)'(32);
    localparam logic [CW:0]   DS_LIM   = (CW+1)'(DATA_WORDS);

    // pipeline control and state
    logic            clearing_reg;
    logic [CW-1:0]   clr_cnt_reg;
    logic [31:0]     pc_reg;
    logic            e_valid_reg;
    logic [31:0]     e_instr_reg;
    logic            r1_valid_reg;
    pipe_t           r1_reg;
    logic            r2_valid_reg;
    pipe_t           r2_reg;
    logic            m_valid_reg;
    pipe_t           m_reg;
    logic [DAW-1:0]  m_sidx_reg;
    logic            w_valid_reg;
    logic [4:0]      w_rd_reg;
    logic [31:0]     w_value_reg;
    logic            out_valid_reg;
    pipe_t           out_reg;
    logic [4:0]      out_sidx_reg;

    logic            adv;
    logic            hazard;
    logic            e_go;
    logic            accept;
    logic [4:0]      e_rs1;
    logic [4:0]      e_rs2;
    logic [31:0]     op_a;
    logic [31:0]     op_b;
    exec_t           ex;

    logic            rf_we;
    logic [4:0]      rf_waddr;
    logic [31:0]     rf_wdata;
    logic [4:0]      rf_ra1;
    logic [4:0]      rf_ra2;
    logic [31:0]     rf_rd1;
    logic [31:0]     rf_rd2;
    logic            wb_we;
    logic            rf_clr_we;

    logic            ds_we;
    logic [DAW-1:0]  ds_waddr;
    logic [31:0]     ds_wdata;
    logic [31:0]     ds_rdata;
    logic            ds_clr_we;
    logic [DAW-1:0]  word_idx;

    logic [31:0]     byte_sh;
    logic [31:0]     ld_value;
    logic [31:0]     m_value;
    logic [31:0]     sidx_ext;
    pipe_t           m_out;

    // load data arriving from the data store
    assign byte_sh  = ds_rdata >> {m_reg.boff, 3'b000};
    assign ld_value = m_reg.is_lb ? {{24{byte_sh[7]}}, byte_sh[7:0]} : ds_rdata;
    assign m_value  = (m_reg.wr && m_reg.is_load) ? ld_value : m_reg.wval;

    // operand value, youngest producer first
    function automatic logic [31:0] fwd(input logic [4:0] src, input logic [31:0] ram_val);
        logic [31:0] v;
        priority if (src == '0)                                        v = '0;
        else if (r1_valid_reg && r1_reg.wr && r1_reg.rd == src)        v = r1_reg.wval;
        else if (r2_valid_reg && r2_reg.wr && r2_reg.rd == src)        v = r2_reg.wval;
        else if (m_valid_reg && m_reg.wr && m_reg.rd == src)           v = m_value;
        else if (w_valid_reg && w_rd_reg == src)                       v = w_value_reg;
        else                                                           v = ram_val;
        return v;
    endfunction

    // a load still ahead of its data
    function automatic logic ld_hit(input logic [4:0] src);
        return (r1_valid_reg && r1_reg.wr && r1_reg.is_load && r1_reg.rd == src) ||
               (r2_valid_reg && r2_reg.wr && r2_reg.is_load && r2_reg.rd == src);
    endfunction

    // handshake and interlock
    assign e_rs1    = e_instr_reg[19:15];
    assign e_rs2    = e_instr_reg[24:20];
    assign adv      = !out_valid_reg || !out_stall;

    always_comb
    begin
        hazard = e_valid_reg &&
                 ((uses_rs1(e_instr_reg) && ld_hit(e_rs1)) ||
                  (uses_rs2(e_instr_reg) && ld_hit(e_rs2)));
    end

    assign e_go     = e_valid_reg && !hazard;
    assign in_stall = clearing_reg || !adv || hazard;
    assign accept   = in_valid && !in_stall;

    // execute stage
    always_comb
    begin
        op_a = fwd(e_rs1, rf_rd1);
        op_b = fwd(e_rs2, rf_rd2);
    end

    rv32ex_alu u_alu (
        .instr (e_instr_reg),
        .pc    (pc_reg),
        .a     (op_a),
        .b     (op_b),
        .ex    (ex)
    );

    // register file: two copies for two reads, re-read every cycle
    assign rf_ra1    = accept ? instr_word[19:15] : e_rs1;
    assign rf_ra2    = accept ? instr_word[24:20] : e_rs2;
    assign wb_we     = adv && m_valid_reg && m_reg.wr;
    assign rf_clr_we = clearing_reg && ({1'b0, clr_cnt_reg} < RF_LIM);
    assign rf_we     = clearing_reg ? rf_clr_we : wb_we;
    assign rf_waddr  = clearing_reg ? clr_cnt_reg[4:0] : m_reg.rd;
    assign rf_wdata  = clearing_reg ? rf_reset_value(clr_cnt_reg[4:0]) : m_value;

    rv32ex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (1'b1),
        .raddr (rf_ra1),
        .rdata (rf_rd1)
    );

    rv32ex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (1'b1),
        .raddr (rf_ra2),
        .rdata (rf_rd2)
    );

    // word index reduction across R1 and R2
    rv32ex_widx #(.DATA_WORDS(DATA_WORDS)) u_widx (
        .clk        (clk),
        .en         (adv),
        .word_addr  (ex.addr[31:2]),
        .word_index (word_idx)
    );

    // data store, accessed in order from R2
    assign ds_clr_we = clearing_reg && ({1'b0, clr_cnt_reg} < DS_LIM);
    assign ds_we     = clearing_reg ? ds_clr_we : (adv && r2_valid_reg && r2_reg.st);
    assign ds_waddr  = clearing_reg ? clr_cnt_reg[DAW-1:0] : word_idx;
    assign ds_wdata  = clearing_reg ? 32'd0 : r2_reg.sval;

    rv32ex_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_ds (
        .clk   (clk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .re    (adv),
        .raddr (word_idx),
        .rdata (ds_rdata)
    );

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == CLR_LAST)
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
        end
    end

    // program counter: config load, else follow the retiring execute word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (start_address_we)
        begin
            pc_reg <= start_address;
        end
        else if (adv && e_go)
        begin
            pc_reg <= ex.res.next_pc;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (accept)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_go)
            begin
                e_valid_reg <= 1'b0;
            end
            r1_valid_reg  <= e_go;
            r2_valid_reg  <= r1_valid_reg;
            m_valid_reg   <= r2_valid_reg;
            w_valid_reg   <= m_valid_reg && m_reg.wr;
            out_valid_reg <= m_valid_reg;
        end
    end

    // retiring word with its load data merged in
    always_comb
    begin
        m_out      = m_reg;
        m_out.wval = m_value;
    end

    // stage payloads
    assign sidx_ext = 32'(m_sidx_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                e_instr_reg <= instr_word;
            end
            r1_reg       <= ex.res;
            r2_reg       <= r1_reg;
            m_reg        <= r2_reg;
            m_sidx_reg   <= word_idx;
            w_rd_reg     <= m_reg.rd;
            w_value_reg  <= m_value;
            out_reg      <= m_out;
            out_sidx_reg <= m_reg.st ? sidx_ext[4:0] : '0;
        end
    end

    // result word
    assign out_valid          = out_valid_reg;
    assign next_fetch_address = out_reg.next_pc;
    assign reg_write_valid    = out_reg.wr;
    assign reg_write_index    = out_reg.rd;
    assign reg_write_value    = out_reg.wval;
    assign store_valid        = out_reg.st;
    assign store_word_index   = out_sidx_reg;
    assign store_value        = out_reg.sval;
    assign branch_taken       = out_reg.taken;
    assign unsupported        = out_reg.bad;

endmodule

`default_nettype wire

### rtl/rv32ex_ram.sv
// Generic single-write, single-read RAM with registered read data (read-before-write).
// No dependencies.
`default_nettype none

module rv32ex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/rv32ex_widx.sv
// Two-stage word index reduction: (byte address >> 2) mod DATA_WORDS.
// Reciprocal multiply, then a narrow multiply-subtract with one correction. No dependencies.
`default_nettype none

module rv32ex_widx #(
    parameter int DATA_WORDS = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [29:0]                   word_addr,
    output logic [$clog2(DATA_WORDS)-1:0] word_index
);

    localparam int L  = $clog2(DATA_WORDS);
    localparam int S  = 30 + L;
    localparam int QW = 31 - L;
    localparam int RW = L + 1;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << S) / 64'(DATA_WORDS);
    localparam logic [30:0]   RECIP      = RECIP_FULL[30:0];
    localparam logic [RW-1:0] DIV_C      = RW'(DATA_WORDS);

    logic [29:0]     x1_reg;
    logic [QW-1:0]   q_reg;
    logic [RW-1:0]   x2_reg;
    logic [60:0]     prod;
    logic [2*RW-1:0] qd_full;
    logic [RW-1:0]   rem;
    logic [RW-1:0]   rem_fix;

    // quotient estimate, low by at most one
    assign prod = {31'd0, x1_reg} * {30'd0, RECIP};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= word_addr;
            q_reg  <= prod[S +: QW];
            x2_reg <= x1_reg[RW-1:0];
        end
    end

    // remainder lies below twice the divisor, so low bits suffice
    assign qd_full    = (2*RW)'(q_reg[RW-1:0]) * (2*RW)'(DIV_C);
    assign rem        = x2_reg - qd_full[RW-1:0];
    assign rem_fix    = (rem >= DIV_C) ? (rem - DIV_C) : rem;
    assign word_index = rem_fix[L-1:0];

endmodule

`default_nettype wire

### rtl/rv32ex_alu.sv
// Execute stage: decode, ALU, branch resolution and data address for one word.
// Depends on rv32ex_pkg.
`default_nettype none

module rv32ex_alu (
    input  logic [31:0]        instr,
    input  logic [31:0]        pc,
    input  logic [31:0]        a,
    input  logic [31:0]        b,
    output rv32ex_pkg::exec_t  ex
);

    import rv32ex_pkg::*;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic        wr_raw;
    logic [31:0] val;
    logic        cond;

    // field split and immediates
    assign opc   = instr[6:0];
    assign rd    = instr[11:7];
    assign f3    = instr[14:12];
    assign f7    = instr[31:25];
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

    // decode and execute
    always_comb
    begin
        ex          = '0;
        wr_raw      = 1'b0;
        val         = '0;
        cond        = 1'b0;
        ex.res.next_pc = pc + 32'd4;
        ex.addr     = a + ((opc == OPC_STORE) ? imm_s : imm_i);
        ex.res.boff = ex.addr[1:0];
        unique case (opc)
            OPC_OP:
            begin
                wr_raw = 1'b1;
                priority if (f7 == F7_BASE && f3 == F3_ADDSUB) val = a + b;
                else if (f7 == F7_ALT && f3 == F3_ADDSUB)      val = a - b;
                else if (f7 == F7_BASE && f3 == F3_AND)        val = a & b;
                else if (f7 == F7_BASE && f3 == F3_OR)         val = a | b;
                else if (f7 == F7_BASE && f3 == F3_XOR)        val = a ^ b;
                else if (f7 == F7_BASE && f3 == F3_SLL)        val = a << b[4:0];
                else if (f7 == F7_BASE && f3 == F3_SRL)        val = a >> b[4:0];
                else
                begin
                    wr_raw     = 1'b0;
                    ex.res.bad = 1'b1;
                end
            end
            OPC_LOAD:
            begin
                priority if (f3 == F3_LW)
                begin
                    wr_raw         = 1'b1;
                    ex.res.is_load = 1'b1;
                end
                else if (f3 == F3_LB)
                begin
                    wr_raw         = 1'b1;
                    ex.res.is_load = 1'b1;
                    ex.res.is_lb   = 1'b1;
                end
                else
                begin
                    ex.res.bad = 1'b1;
                end
            end
            OPC_STORE:
            begin
                if (f3 == F3_SW)
                begin
                    ex.res.st   = 1'b1;
                    ex.res.sval = b;
                end
                else
                begin
                    ex.res.bad = 1'b1;
                end
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    F3_BEQ:  cond = (a == b);
                    F3_BNE:  cond = (a != b);
                    F3_BLT:  cond = ($signed(a) < $signed(b));
                    F3_BGE:  cond = !($signed(a) < $signed(b));
                    default: ex.res.bad = 1'b1;
                endcase
                if (!ex.res.bad && cond)
                begin
                    ex.res.taken   = 1'b1;
                    ex.res.next_pc = pc + imm_b;
                end
            end
            OPC_JAL:
            begin
                wr_raw         = 1'b1;
                val            = pc + 32'd4;
                ex.res.taken   = 1'b1;
                ex.res.next_pc = pc + imm_j;
            end
            default:
            begin
                ex.res.bad = 1'b1;
            end
        endcase

        // writes to x0 are dropped and not reported
        ex.res.wr   = wr_raw && (rd != '0);
        ex.res.rd   = ex.res.wr ? rd : '0;
        ex.res.wval = ex.res.wr ? val : '0;
    end

endmodule

`default_nettype wire

### dv/tb_rv32i_subset_execute_unit_top.sv
// Self-checking bench for rv32i_subset_execute_unit_top: directed and random instruction words,
// predicted in-bench against a private copy of the register file, data store and PC.
// Depends on rtl/rv32ex_pkg.sv for opcode and funct constants, and on the top-level RTL.
`default_nettype none

module tb_rv32i_subset_execute_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32ex_pkg::*;

    localparam int DATA_WORDS   = 32;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_WORDS  = 245;
    localparam int QUIET_WORDS  = 150;
    localparam int CFG_SETTLE   = 8;
    localparam int END_SETTLE   = 20;
    localparam int LONG_HOLD    = 64;
    localparam int STALL_LIMIT  = 2000;

    // Encodings outside the subset, used to provoke the unsupported flag
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [2:0] F3_LH      = 3'b001;
    localparam logic [2:0] F3_SB      = 3'b000;
    localparam logic [2:0] F3_BR_BAD  = 3'b010;

    // One retired instruction, in port order
    typedef struct packed {
        logic [31:0] next_fetch_address;
        logic        reg_write_valid;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        store_valid;
        logic [4:0]  store_word_index;
        logic [31:0] store_value;
        logic        branch_taken;
        logic        unsupported;
    } exec_result_t;

    // Architectural shadow of the unit plus the queue of retirements still due
    class rv32_retire_checker;
        logic [31:0]  pc;
        logic [31:0]  regs [32];
        logic [31:0]  dstore [DATA_WORDS];
        exec_result_t pending_results [$];
        int           errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dstore[i]) dstore[i] = '0;
            regs[1] = 32'd11;
            regs[3] = 32'd3;
            regs[5] = 32'd1;
            pc      = '0;
            errors  = 0;
        endfunction

        function void load_start_address(logic [31:0] value);
            pc = value;
        endfunction

        // Execute one accepted word against the shadow state; x0 is never written
        function void note_instruction(logic [31:0] w);
            exec_result_t r;
            logic [31:0]  a, b, addr, imm, word, wval;
            logic [7:0]   lane;
            logic [4:0]   rd;
            logic [2:0]   f3;
            logic [6:0]   f7;
            logic         wr, cond;
            r    = '0;
            rd   = w[11:7];
            f3   = w[14:12];
            f7   = w[31:25];
            a    = regs[w[19:15]];
            b    = regs[w[24:20]];
            wr   = 1'b0;
            wval = '0;
            cond = 1'b0;
            r.next_fetch_address = pc + 32'd4;
            case (w[6:0])
                OPC_OP:
                begin
                    wr = 1'b1;
                    if (f7 == F7_BASE && f3 == F3_ADDSUB)     wval = a + b;
                    else if (f7 == F7_ALT && f3 == F3_ADDSUB) wval = a - b;
                    else if (f7 == F7_BASE && f3 == F3_AND)   wval = a & b;
                    else if (f7 == F7_BASE && f3 == F3_OR)    wval = a | b;
                    else if (f7 == F7_BASE && f3 == F3_XOR)   wval = a ^ b;
                    else if (f7 == F7_BASE && f3 == F3_SLL)   wval = a << b[4:0];
                    else if (f7 == F7_BASE && f3 == F3_SRL)   wval = a >> b[4:0];
                    else
                    begin
                        wr = 1'b0;
                        r.unsupported = 1'b1;
                    end
                end
                OPC_LOAD:
                begin
                    addr = a + {{20{w[31]}}, w[31:20]};
                    word = dstore[(addr >> 2) % DATA_WORDS];
                    lane = word[addr[1:0] * 8 +: 8];
                    if (f3 == F3_LW)
                    begin
                        wr   = 1'b1;
                        wval = word;
                    end
                    else if (f3 == F3_LB)
                    begin
                        wr   = 1'b1;
                        wval = {{24{lane[7]}}, lane};
                    end
                    else
                        r.unsupported = 1'b1;
                end
                OPC_STORE:
                begin
                    if (f3 == F3_SW)
                    begin
                        addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
                        r.store_valid      = 1'b1;
                        r.store_word_index = 5'((addr >> 2) % DATA_WORDS);
                        r.store_value      = b;
                        dstore[(addr >> 2) % DATA_WORDS] = b;
                    end
                    else
                        r.unsupported = 1'b1;
                end
                OPC_BRANCH:
                begin
                    imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    case (f3)
                        F3_BEQ:  cond = (a == b);
                        F3_BNE:  cond = (a != b);
                        F3_BLT:  cond = ($signed(a) < $signed(b));
                        F3_BGE:  cond = ($signed(a) >= $signed(b));
                        default: r.unsupported = 1'b1;
                    endcase
                    if (cond)
                    begin
                        r.branch_taken       = 1'b1;
                        r.next_fetch_address = pc + imm;
                    end
                end
                OPC_JAL:
                begin
                    imm  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                    wr   = 1'b1;
                    wval = pc + 32'd4;
                    r.branch_taken       = 1'b1;
                    r.next_fetch_address = pc + imm;
                end
                default:
                    r.unsupported = 1'b1;
            endcase
            if (wr && rd != 5'd0)
            begin
                regs[rd]          = wval;
                r.reg_write_valid = 1'b1;
                r.reg_write_index = rd;
                r.reg_write_value = wval;
            end
            pc = r.next_fetch_address;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Match a retired word against the oldest prediction
        function void check_result(exec_result_t got);
            exec_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result word: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("next_fetch_address", want.next_fetch_address, got.next_fetch_address);
            compare_field("reg_write_valid", want.reg_write_valid, got.reg_write_valid);
            compare_field("reg_write_index", want.reg_write_index, got.reg_write_index);
            compare_field("reg_write_value", want.reg_write_value, got.reg_write_value);
            compare_field("store_valid", want.store_valid, got.store_valid);
            compare_field("store_word_index", want.store_word_index, got.store_word_index);
            compare_field("store_value", want.store_value, got.store_value);
            compare_field("branch_taken", want.branch_taken, got.branch_taken);
            compare_field("unsupported", want.unsupported, got.unsupported);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start_address_we;
    logic [31:0]        start_address;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        instr_word;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        next_fetch_address;
    logic               reg_write_valid;
    logic [4:0]         reg_write_index;
    logic signed [31:0] reg_write_value;
    logic               store_valid;
    logic [4:0]         store_word_index;
    logic signed [31:0] store_value;
    logic               branch_taken;
    logic               unsupported;

    rv32_retire_checker retire;
    logic               idling_on;
    logic               long_hold_req;

    rv32i_subset_execute_unit_top #(
        .DATA_WORDS(DATA_WORDS)
    ) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start_address_we   (start_address_we),
        .start_address      (start_address),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .instr_word         (instr_word),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .next_fetch_address (next_fetch_address),
        .reg_write_valid    (reg_write_valid),
        .reg_write_index    (reg_write_index),
        .reg_write_value    (reg_write_value),
        .store_valid        (store_valid),
        .store_word_index   (store_word_index),
        .store_value        (store_value),
        .branch_taken       (branch_taken),
        .unsupported        (unsupported)
    );

    // Instruction encoders
    function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] i_word(input logic [11:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3, input logic [4:0] rd);
        return {imm, rs1, f3, rd, OPC_LOAD};
    endfunction

    function automatic logic [31:0] s_word(input logic [11:0] imm, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] b_word(input logic [12:0] imm, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] j_word(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // Mostly low registers so that back-to-back words depend on each other
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    // Mostly well-formed words with random operands; the rest broken or pure noise
    function automatic logic [31:0] random_instruction();
        logic [4:0]  rd, rs1, rs2;
        logic [31:0] noise;
        int          pick;
        rd    = pick_reg();
        rs1   = pick_reg();
        rs2   = pick_reg();
        noise = $urandom();
        pick  = $urandom_range(0, 99);
        if (pick < 35)
        begin
            case ($urandom_range(0, 6))
                0:       return r_word(F7_BASE, rs2, rs1, F3_ADDSUB, rd);
                1:       return r_word(F7_ALT, rs2, rs1, F3_ADDSUB, rd);
                2:       return r_word(F7_BASE, rs2, rs1, F3_AND, rd);
                3:       return r_word(F7_BASE, rs2, rs1, F3_OR, rd);
                4:       return r_word(F7_BASE, rs2, rs1, F3_XOR, rd);
                5:       return r_word(F7_BASE, rs2, rs1, F3_SLL, rd);
                default: return r_word(F7_BASE, rs2, rs1, F3_SRL, rd);
            endcase
        end
        if (pick < 50)
            return i_word(noise[11:0], rs1, noise[12] ? F3_LW : F3_LB, rd);
        if (pick < 65)
            return s_word(noise[11:0], rs2, rs1, F3_SW);
        if (pick < 80)
        begin
            case (noise[14:13])
                2'd0:    return b_word({noise[11:0], 1'b0}, rs2, rs1, F3_BEQ);
                2'd1:    return b_word({noise[11:0], 1'b0}, rs2, rs1, F3_BNE);
                2'd2:    return b_word({noise[11:0], 1'b0}, rs2, rs1, F3_BLT);
                default: return b_word({noise[11:0], 1'b0}, rs2, rs1, F3_BGE);
            endcase
        end
        if (pick < 85)
            return j_word({noise[19:0], 1'b0}, rd);
        if (pick < 93)
        begin
            // supported opcode, random remainder: often a bad funct field
            case ($urandom_range(0, 3))
                0:       return {noise[31:7], OPC_OP};
                1:       return {noise[31:7], OPC_LOAD};
                2:       return {noise[31:7], OPC_STORE};
                default: return {noise[31:7], OPC_BRANCH};
            endcase
        end
        return noise;
    endfunction

    // Offer one word and hold it until the unit takes it
    task automatic send_word(input logic [31:0] w);
        in_valid   <= 1'b1;
        instr_word <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        retire.note_instruction(w);
    endtask

    // Reprogram the start address once the pipe has drained
    task automatic set_start_address(input logic [31:0] value);
        while (retire.pending_results.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        start_address_we <= 1'b1;
        start_address    <= value;
        @(posedge clk);
        start_address_we <= 1'b0;
        retire.load_start_address(value);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall bursts, plus one long hold-off to back the pipe up
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every retired word
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            retire.check_result({next_fetch_address, reg_write_valid, reg_write_index,
                                 reg_write_value, store_valid, store_word_index, store_value,
                                 branch_taken, unsupported});
    end

    // Watchdog: too long without any word moving on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_rv32i_subset_execute_unit_top: errors");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        logic [31:0] directed [$];
        logic [31:0] starts [NUM_PHASES];
        retire           = new();
        idling_on        = 1'b1;
        long_hold_req    = 1'b0;
        rst_n            = 1'b0;
        start_address_we = 1'b0;
        start_address    = '0;
        in_valid         = 1'b0;
        instr_word       = '0;

        // x1=11, x3=3, x5=1 out of reset; PC starts at zero
        directed.push_back(r_word(F7_BASE, 5'd3, 5'd1, F3_ADDSUB, 5'd2));   // x2 = 14
        directed.push_back(r_word(F7_ALT, 5'd1, 5'd0, F3_ADDSUB, 5'd4));    // x4 = -11
        directed.push_back(r_word(F7_BASE, 5'd1, 5'd4, F3_AND, 5'd6));
        directed.push_back(r_word(F7_BASE, 5'd5, 5'd4, F3_OR, 5'd7));
        directed.push_back(r_word(F7_BASE, 5'd3, 5'd4, F3_XOR, 5'd8));
        directed.push_back(r_word(F7_BASE, 5'd4, 5'd5, F3_SLL, 5'd9));      // shift uses low 5 bits
        directed.push_back(r_word(F7_BASE, 5'd3, 5'd4, F3_SRL, 5'd10));     // logical, not arithmetic
        directed.push_back(r_word(F7_BASE, 5'd1, 5'd1, F3_ADDSUB, 5'd0));   // write to x0 dropped
        directed.push_back(s_word(12'h000, 5'd4, 5'd0, F3_SW));
        directed.push_back(s_word(12'hFFC, 5'd2, 5'd0, F3_SW));             // address wraps to top word
        directed.push_back(s_word(12'h7FF, 5'd1, 5'd1, F3_SW));
        directed.push_back(i_word(12'h800, 5'd0, F3_LW, 5'd11));
        directed.push_back(i_word(12'h001, 5'd0, F3_LB, 5'd12));            // byte lanes, sign-extended
        directed.push_back(i_word(12'h000, 5'd0, F3_LB, 5'd13));
        directed.push_back(i_word(12'hFFC, 5'd0, F3_LB, 5'd14));
        directed.push_back(i_word(12'hFFE, 5'd0, F3_LB, 5'd15));
        directed.push_back(i_word(12'h003, 5'd0, F3_LB, 5'd16));
        directed.push_back(b_word(13'h0008, 5'd1, 5'd1, F3_BEQ));
        directed.push_back(b_word(13'h0008, 5'd1, 5'd1, F3_BNE));
        directed.push_back(b_word(13'h1000, 5'd1, 5'd4, F3_BLT));           // signed compare
        directed.push_back(b_word(13'h0FFE, 5'd1, 5'd4, F3_BGE));
        directed.push_back(b_word(13'h0FFE, 5'd4, 5'd1, F3_BGE));
        directed.push_back(j_word(21'h100000, 5'd31));
        directed.push_back(j_word(21'h0FFFFE, 5'd0));
        directed.push_back({12'h001, 5'd1, F3_ADDSUB, 5'd2, OPC_OP_IMM});
        directed.push_back(r_word(F7_ALT, 5'd1, 5'd1, F3_SLL, 5'd2));
        directed.push_back(i_word(12'h000, 5'd0, F3_LH, 5'd2));
        directed.push_back(s_word(12'h000, 5'd1, 5'd0, F3_SB));
        directed.push_back(b_word(13'h0008, 5'd1, 5'd1, F3_BR_BAD));
        directed.push_back(32'hFFFF_FFFF);
        directed.push_back(32'h0000_0000);

        // Start addresses: top of memory (PC wraps at once), zero, random aligned, unaligned, random aligned
        starts[0] = 32'hFFFF_FFFC;
        starts[1] = 32'h0000_0000;
        starts[2] = $urandom() & 32'hFFFF_FFFC;
        starts[3] = {30'($urandom_range(0, 30'h3FFF_FFFE)), 2'b11};
        starts[4] = $urandom() & 32'hFFFF_FFFC;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_word(directed[i]);
        in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_start_address(starts[p]);
            idling_on = (p != 2);
            if (p == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == NUM_PHASES - 1 && n >= PHASE_WORDS - QUIET_WORDS)
                    idling_on = 1'b0;
                send_word(random_instruction());
                if (idling_on && $urandom_range(0, 4) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 7)) @(posedge clk);
                end
            end
            in_valid <= 1'b0;
        end

        // Drain, then give stray results a chance to show up
        while (retire.pending_results.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (retire.errors == 0)
            $display("tb_rv32i_subset_execute_unit_top: clean");
        else
            $display("tb_rv32i_subset_execute_unit_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
